// ===== hdl/jsv_pkg.sv =====
package jsv_pkg;

  localparam int MAX_NESTING = 64;
  localparam int STK_AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int DEPTH_W = 7;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 7'd64;
  localparam int QDEPTH = 2;

  typedef enum logic [4:0] {
    S_START  = 5'd0,
    S_DONE   = 5'd1,
    S_KEY    = 5'd2,
    S_COLON  = 5'd3,
    S_VALUE  = 5'd4,
    S_AFTER  = 5'd5,
    S_KSTR   = 5'd8,
    S_KESC   = 5'd9,
    S_KHEX   = 5'd10,
    S_KSBS   = 5'd11,
    S_KSU    = 5'd12,
    S_VSTR   = 5'd13,
    S_VESC   = 5'd14,
    S_VHEX   = 5'd15,
    S_VSBS   = 5'd16,
    S_VSU    = 5'd17,
    S_NMINUS = 5'd18,
    S_NZERO  = 5'd19,
    S_NINT   = 5'd20,
    S_NDOT   = 5'd21,
    S_NFRAC  = 5'd22,
    S_NE     = 5'd23,
    S_NESIGN = 5'd24,
    S_NEXP   = 5'd25,
    S_LNULL  = 5'd26,
    S_LTRUE  = 5'd27,
    S_LFALSE = 5'd28
  } pstate_t;

  localparam logic [3:0] EV_NONE   = 4'd0;
  localparam logic [3:0] EV_OOPEN  = 4'd1;
  localparam logic [3:0] EV_OCLOSE = 4'd2;
  localparam logic [3:0] EV_AOPEN  = 4'd3;
  localparam logic [3:0] EV_ACLOSE = 4'd4;
  localparam logic [3:0] EV_KEY    = 4'd5;
  localparam logic [3:0] EV_STR    = 4'd6;
  localparam logic [3:0] EV_NUM    = 4'd7;
  localparam logic [3:0] EV_LIT    = 4'd8;
  localparam logic [3:0] EV_END    = 4'd9;

  localparam logic [2:0] ER_OK    = 3'd0;
  localparam logic [2:0] ER_UNEXP = 3'd1;
  localparam logic [2:0] ER_END   = 3'd2;
  localparam logic [2:0] ER_CTRL  = 3'd3;
  localparam logic [2:0] ER_ESC   = 3'd4;
  localparam logic [2:0] ER_SURR  = 3'd5;
  localparam logic [2:0] ER_DEEP  = 3'd6;
  localparam logic [2:0] ER_NUM   = 3'd7;

  typedef enum logic [2:0] {
    C_WS, C_DIGIT, C_HEXA, C_CTRL, C_OTHER
  } cls_t;

  typedef struct packed {
    logic [7:0] c;
    logic       eoi;
    logic       ws;
    logic       dig;
    logic       hexok;
    logic [3:0] hexv;
    logic       ctrl;
  } tok_t;

  typedef struct packed {
    logic [3:0]         ev;
    logic [7:0]         val;
    logic               uv;
    logic [15:0]        cu;
    logic               ne;
    logic [DEPTH_W-1:0] dep;
    logic [2:0]         err;
  } res_t;

  function automatic logic [7:0] lit_char(input pstate_t s, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (s)
      S_LNULL: case (i)
        3'd0: ch = "n"; 3'd1: ch = "u"; 3'd2: ch = "l"; 3'd3: ch = "l";
        default: ch = 8'h00;
      endcase
      S_LTRUE: case (i)
        3'd0: ch = "t"; 3'd1: ch = "r"; 3'd2: ch = "u"; 3'd3: ch = "e";
        default: ch = 8'h00;
      endcase
      default: case (i)
        3'd0: ch = "f"; 3'd1: ch = "a"; 3'd2: ch = "l"; 3'd3: ch = "s";
        3'd4: ch = "e";
        default: ch = 8'h00;
      endcase
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/jsv_front.sv =====
module jsv_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          valid,
  output logic          stall,
  input  logic [7:0]    data_byte,
  input  logic          end_of_input,
  output logic          q_valid,
  input  logic          q_stall,
  output jsv_pkg::tok_t q_tok
);
  import jsv_pkg::*;

  tok_t mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wp, rp;
  logic [$clog2(QDEPTH):0] cnt;
  tok_t t;
  logic push, pop;

  always_comb begin
    t.c     = data_byte;
    t.eoi   = end_of_input;
    t.ws    = data_byte == 8'h20 || data_byte == 8'h09 ||
              data_byte == 8'h0D || data_byte == 8'h0A;
    t.dig   = data_byte >= "0" && data_byte <= "9";
    t.ctrl  = data_byte < 8'h20;
    t.hexok = 1'b1;
    t.hexv  = 4'd0;
    if (t.dig) t.hexv = 4'(data_byte - "0");
    else if (data_byte >= "a" && data_byte <= "f") t.hexv = 4'(data_byte - "a" + 8'd10);
    else if (data_byte >= "A" && data_byte <= "F") t.hexv = 4'(data_byte - "A" + 8'd10);
    else t.hexok = 1'b0;
  end

  assign stall   = cnt == ($clog2(QDEPTH)+1)'(QDEPTH);
  assign push    = valid && !stall;
  assign q_valid = cnt != '0;
  assign pop     = q_valid && !q_stall;
  assign q_tok   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
    end
  end
endmodule

// ===== hdl/jsv_back.sv =====
module jsv_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [jsv_pkg::DEPTH_W-1:0]    cfg_data,
  input  logic                           q_valid,
  output logic                           q_stall,
  input  jsv_pkg::tok_t                  q_tok,
  output logic                           o_valid,
  input  logic                           o_stall,
  output jsv_pkg::res_t                  o_res
);
  import jsv_pkg::*;

  pstate_t st, st_next;
  logic stk [MAX_NESTING];
  logic top;
  logic [DEPTH_W-1:0] lvl, lvl_next, max_depth;
  logic emp, emp_next, hsp, hsp_next;
  logic [2:0] li, li_next, hc, hc_next, el, el_next;
  logic [15:0] hacc, hacc_next;
  logic push_w, push_obj;
  logic [DEPTH_W-1:0] lim;
  logic top_obj, go;
  res_t r;
  logic [7:0] c;

  assign q_stall = o_valid && o_stall;
  assign go = q_valid && !q_stall;
  assign lim = (max_depth < DEPTH_W'(MAX_NESTING)) ? max_depth : DEPTH_W'(MAX_NESTING);
  assign top_obj = (lvl != '0) ? top : 1'b0;
  assign c = q_tok.c;

  always_comb begin
    logic redo, ne, hi, lo, take, need;
    logic [15:0] u;
    pstate_t s, nx;
    st_next = st; lvl_next = lvl; emp_next = emp; li_next = li;
    hc_next = hc; hacc_next = hacc; hsp_next = hsp; el_next = el;
    push_w = 1'b0; push_obj = 1'b0;
    r = '0;
    ne = 1'b0; redo = 1'b0; u = '0; hi = 1'b0; lo = 1'b0;
    take = 1'b1; need = 1'b0; nx = st;
    r.dep = lvl;
    if (q_tok.eoi) begin
      r.err = el;
      if (el == ER_OK && st != S_DONE) r.err = ER_END;
      r.ev = (r.err != ER_OK) ? EV_NONE : EV_END;
      st_next = S_START; lvl_next = '0; emp_next = 1'b1; li_next = '0;
      hc_next = '0; hacc_next = '0; hsp_next = 1'b0; el_next = ER_OK;
    end else if (el != ER_OK) begin
      r.err = el;
    end else begin
      s = st;
      if (s inside {[S_NMINUS:S_NEXP]}) begin
        case (s)
          S_NMINUS: if (c == "0") nx = S_NZERO; else if (q_tok.dig) nx = S_NINT;
                    else take = 1'b0;
          S_NZERO:  if (c == ".") nx = S_NDOT; else if (c == "e" || c == "E") nx = S_NE;
                    else take = 1'b0;
          S_NINT:   if (c == ".") nx = S_NDOT; else if (c == "e" || c == "E") nx = S_NE;
                    else if (!q_tok.dig) take = 1'b0;
          S_NDOT:   if (q_tok.dig) nx = S_NFRAC; else take = 1'b0;
          S_NFRAC:  if (c == "e" || c == "E") nx = S_NE; else if (!q_tok.dig) take = 1'b0;
          S_NE:     if (c == "+" || c == "-") nx = S_NESIGN; else if (q_tok.dig) nx = S_NEXP;
                    else take = 1'b0;
          S_NESIGN: if (q_tok.dig) nx = S_NEXP; else take = 1'b0;
          default:  if (!q_tok.dig) take = 1'b0;
        endcase
        need = s == S_NMINUS || s == S_NDOT || s == S_NE || s == S_NESIGN;
        if (take) begin
          st_next = nx; r.ev = EV_NUM;
        end else if (need) el_next = ER_NUM;
        else begin
          ne = 1'b1; redo = 1'b1; s = S_AFTER; st_next = S_AFTER;
        end
      end
      if (!(s inside {[S_NMINUS:S_NEXP]})) begin
        case (s)
          S_START: if (!q_tok.ws) begin
            if (c == "{" || c == "[") begin
              if (lvl >= lim) el_next = ER_DEEP;
              else begin
                push_w = 1'b1; push_obj = c == "{"; lvl_next = lvl + 1'b1; emp_next = 1'b1;
                st_next = (c == "{") ? S_KEY : S_VALUE;
                r.ev = (c == "{") ? EV_OOPEN : EV_AOPEN;
              end
            end else el_next = ER_UNEXP;
          end
          S_DONE: ;
          S_KEY: if (!q_tok.ws) begin
            if (c == "\"") begin emp_next = 1'b0; st_next = S_KSTR; end
            else if (c == "}" && emp) begin
              r.ev = top_obj ? EV_OCLOSE : EV_ACLOSE;
              lvl_next = (lvl != '0) ? lvl - 1'b1 : lvl; emp_next = 1'b0;
              st_next = (lvl_next != '0) ? S_AFTER : S_DONE;
            end else el_next = ER_UNEXP;
          end
          S_COLON: if (!q_tok.ws) begin
            if (c == ":") begin emp_next = 1'b0; st_next = S_VALUE; end
            else el_next = ER_UNEXP;
          end
          S_VALUE: if (!q_tok.ws) begin
            if (c == "{" || c == "[") begin
              if (lvl >= lim) el_next = ER_DEEP;
              else begin
                push_w = 1'b1; push_obj = c == "{"; lvl_next = lvl + 1'b1; emp_next = 1'b1;
                st_next = (c == "{") ? S_KEY : S_VALUE;
                r.ev = (c == "{") ? EV_OOPEN : EV_AOPEN;
              end
            end else if (c == "]" && emp && lvl != '0 && !top_obj) begin
              r.ev = EV_ACLOSE; lvl_next = lvl - 1'b1; emp_next = 1'b0;
              st_next = (lvl_next != '0) ? S_AFTER : S_DONE;
            end else begin
              emp_next = 1'b0;
              if (c == "\"") st_next = S_VSTR;
              else if (c == "n" || c == "t" || c == "f") begin
                st_next = (c == "n") ? S_LNULL : ((c == "t") ? S_LTRUE : S_LFALSE);
                li_next = 3'd1; r.ev = EV_LIT;
              end else if (c == "-") begin st_next = S_NMINUS; r.ev = EV_NUM; end
              else if (c == "0") begin st_next = S_NZERO; r.ev = EV_NUM; end
              else if (q_tok.dig) begin st_next = S_NINT; r.ev = EV_NUM; end
              else el_next = ER_UNEXP;
            end
          end
          S_AFTER: if (!q_tok.ws) begin
            if (c == ",") begin emp_next = 1'b0; st_next = top_obj ? S_KEY : S_VALUE; end
            else if ((c == "}" && top_obj) || (c == "]" && !top_obj)) begin
              r.ev = top_obj ? EV_OCLOSE : EV_ACLOSE;
              lvl_next = (lvl != '0) ? lvl - 1'b1 : lvl; emp_next = 1'b0;
              st_next = (lvl_next != '0) ? S_AFTER : S_DONE;
            end else el_next = ER_UNEXP;
          end
          S_KSTR, S_VSTR: begin
            if (c == "\"") st_next = (s == S_KSTR) ? S_COLON : S_AFTER;
            else if (q_tok.ctrl) el_next = ER_CTRL;
            else if (c == "\\") st_next = pstate_t'(s + 5'd1);
            else begin r.ev = (s == S_KSTR) ? EV_KEY : EV_STR; r.val = c; end
          end
          S_KESC, S_VESC: begin
            r.ev = (s == S_KESC) ? EV_KEY : EV_STR;
            st_next = pstate_t'(s - 5'd1);
            case (c)
              "\"", "\\", "/": r.val = c;
              "b": r.val = 8'h08;
              "f": r.val = 8'h0C;
              "n": r.val = 8'h0A;
              "r": r.val = 8'h0D;
              "t": r.val = 8'h09;
              "u": begin
                r.ev = EV_NONE; hacc_next = '0; hc_next = '0;
                st_next = pstate_t'(s + 5'd1);
              end
              default: begin el_next = ER_ESC; st_next = st; end
            endcase
          end
          S_KSBS, S_VSBS: if (c == "\\") st_next = pstate_t'(s + 5'd1); else el_next = ER_SURR;
          S_KSU, S_VSU: if (c == "u") begin
            hacc_next = '0; hc_next = '0; st_next = pstate_t'(s - 5'd2);
          end else el_next = ER_SURR;
          S_KHEX, S_VHEX: if (!q_tok.hexok) el_next = ER_ESC;
          else begin
            u = {hacc[11:0], q_tok.hexv};
            hacc_next = u; hc_next = hc + 3'd1;
            if (hc_next >= 3'd4) begin
              hc_next = '0;
              hi = u >= 16'hD800 && u <= 16'hDBFF;
              lo = u >= 16'hDC00 && u <= 16'hDFFF;
              r.uv = 1'b1; r.cu = u;
              if (hsp) begin
                if (!lo) el_next = ER_SURR;
                else begin hsp_next = 1'b0; st_next = pstate_t'(s - 5'd2); end
              end else if (lo) el_next = ER_SURR;
              else if (hi) begin hsp_next = 1'b1; st_next = pstate_t'(s + 5'd1); end
              else st_next = pstate_t'(s - 5'd2);
            end
          end
          S_LNULL, S_LTRUE, S_LFALSE: begin
            if (li >= ((s == S_LFALSE) ? 3'd5 : 3'd4) || lit_char(s, li) != c)
              el_next = ER_UNEXP;
            else begin
              r.ev = EV_LIT; li_next = li + 3'd1;
              if (li_next >= ((s == S_LFALSE) ? 3'd5 : 3'd4)) begin
                li_next = '0; st_next = S_AFTER;
              end
            end
          end
          default: el_next = ER_UNEXP;
        endcase
      end
      r.ne = ne && redo;
      r.err = el_next;
      r.dep = lvl_next;
      if (el_next != ER_OK) begin
        r.ev = '0; r.val = '0; r.uv = 1'b0; r.cu = '0; r.ne = 1'b0;
      end
    end
  end

  // top holds the kind of the innermost open container
  always_ff @(posedge clk) begin
    if (go && push_w) begin
      stk[STK_AW'(lvl)] <= push_obj;
      top <= push_obj;
    end else if (go) begin
      top <= stk[STK_AW'(lvl_next - 1'b1)];
    end
    if (go) o_res <= r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_START; lvl <= '0; emp <= 1'b1; li <= '0; hc <= '0; hacc <= '0;
      hsp <= 1'b0; el <= ER_OK; o_valid <= 1'b0; max_depth <= DEPTH_RESET;
    end else begin
      if (cfg_we) max_depth <= cfg_data;
      if (go) begin
        st <= st_next; lvl <= lvl_next; emp <= emp_next; li <= li_next;
        hc <= hc_next; hacc <= hacc_next; hsp <= hsp_next; el <= el_next;
      end
      if (go) o_valid <= 1'b1;
      else if (!o_stall) o_valid <= 1'b0;
    end
  end
endmodule

// ===== hdl/json_syntax_validator.sv =====
// channel  | handshake                  | payload
// in       | in_valid / in_stall        | data_byte, end_of_input
// out      | out_valid / out_stall      | event_res .. error_kind
// cfg      | cfg_we                     | cfg_data (max_depth)
// One byte per cycle sustained while out_stall is low; a byte passes the queue,
// then the parse register. The parser state update sets the rate.
// rst is synchronous: empties the queue, clears parse state, max_depth 64.
// Output stall backs up into a two-entry queue, then asserts in_stall.
module json_syntax_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_res,
  output logic [7:0]  value_byte,
  output logic        unit_valid,
  output logic [15:0] code_unit,
  output logic        number_ended,
  output logic [6:0]  depth,
  output logic [2:0]  error_kind
);
  import jsv_pkg::*;

  logic q_valid, q_stall;
  tok_t q_tok;
  res_t res;

  jsv_front u_front (
    .clk, .rst, .valid(in_valid), .stall(in_stall), .data_byte, .end_of_input,
    .q_valid, .q_stall, .q_tok
  );

  jsv_back u_back (
    .clk, .rst, .cfg_we, .cfg_data, .q_valid, .q_stall, .q_tok,
    .o_valid(out_valid), .o_stall(out_stall), .o_res(res)
  );

  assign event_res    = res.ev;
  assign value_byte   = res.val;
  assign unit_valid   = res.uv;
  assign code_unit    = res.cu;
  assign number_ended = res.ne;
  assign depth        = res.dep;
  assign error_kind   = res.err;
endmodule

// ===== hdl/jsv_checker.sv =====
module jsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  event_res,
  input logic        unit_valid,
  input logic [15:0] code_unit,
  input logic [6:0]  depth,
  input logic [2:0]  error_kind
);
  import jsv_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_res))
    else $error("output changed under stall");

  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_kind != ER_OK |-> event_res == EV_NONE && !unit_valid)
    else $error("event with error");

  a_cu: assert property (@(posedge clk) disable iff (rst)
    out_valid && !unit_valid |-> code_unit == 16'd0)
    else $error("code unit without valid");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> depth <= 7'(MAX_NESTING))
    else $error("depth out of range");
endmodule

bind json_syntax_validator jsv_checker u_chk (
  .clk, .rst, .out_valid, .out_stall, .event_res, .unit_valid, .code_unit,
  .depth, .error_kind
);
